@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define BSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define BSD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bsd_pkg.sv @@
// Types and constants of the bitmap stream decompressor.
`default_nettype none

package bsd_pkg;

  localparam int MaxRowBytes = 2048;
  localparam int RowAddrW    = $clog2(MaxRowBytes);
  localparam int RowLenW     = RowAddrW + 1;
  localparam int ByteW       = 8;
  localparam int LenW        = 16;
  localparam int FlagPosW    = 4;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 12;
  localparam int ModeW       = 2;

  localparam logic [FlagPosW-1:0] FlagDone = 4'd8;
  localparam logic [ByteW-1:0]    PbNop    = 8'h80;

  localparam logic [CfgIdxW-1:0] CFG_MODE      = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_BYTES = 1'b1;

  localparam logic [ModeW-1:0] MODE_SCAN     = 2'd0;
  localparam logic [ModeW-1:0] MODE_RLE      = 2'd1;
  localparam logic [ModeW-1:0] MODE_PACKBITS = 2'd2;
  localparam logic [ModeW-1:0] MODE_NONE     = 2'd3;

  typedef enum logic [4:0] {
    PH_WAIT_HI = 5'b00001,
    PH_WAIT_LO = 5'b00010,
    PH_HEAD    = 5'b00100,
    PH_BODY    = 5'b01000,
    PH_LITERAL = 5'b10000
  } phase_t;

  typedef enum logic [3:0] {
    CTL_IDLE  = 4'b0001,
    CTL_EXEC  = 4'b0010,
    CTL_DRAIN = 4'b0100,
    CTL_COPY  = 4'b1000
  } ctl_t;

  typedef struct packed {
    logic [RowAddrW-1:0] pos;
    logic [FlagPosW-1:0] fpos;
  } row_step_t;

endpackage

`default_nettype wire

@@ rtl/bsd_if.sv @@
// Valid/ready channel interfaces for input bytes and decoded results.
`default_nettype none

interface bsd_in_if;
  logic                     valid;
  logic                     ready;
  logic [bsd_pkg::ByteW-1:0] data_byte;
  logic                     first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface bsd_out_if;
  logic                     valid;
  logic                     ready;
  logic [bsd_pkg::ByteW-1:0] out_byte;
  logic [bsd_pkg::ByteW-1:0] repeat_count;
  logic                     last_of_item;

  modport source (output valid, out_byte, repeat_count, last_of_item, input ready);
  modport sink   (input valid, out_byte, repeat_count, last_of_item, output ready);
endinterface

`default_nettype wire

@@ rtl/bitmap_stream_decompressor.sv @@
// Bitmap stream decompressor: scan-line, run-length and PackBits decoding.
// An item is accepted, then executed, after any wait for the result register.
// Each previous-row copy adds a row store read, then an emit and write-back, and a
// flag byte walk adds a closing step; the single row store port sets this order.
// Synchronous reset clears control state; the row store needs no clearing pass, a
// fill count marks which entries hold data of the current bitmap.
`default_nettype none

module bitmap_stream_decompressor (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [bsd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire [bsd_pkg::CfgDataW-1:0]  cfg_wdata,
  bsd_in_if.sink                       in_ch,
  bsd_out_if.source                    out_ch
);

  localparam int AW = bsd_pkg::RowAddrW;
  localparam int LW = bsd_pkg::RowLenW;

  function automatic logic [LW-1:0] row_len_f(input logic [bsd_pkg::CfgDataW-1:0] rb);
    logic [LW-1:0] len;
    if (rb == '0) begin
      len = LW'(1);
    end else if (int'(rb) > bsd_pkg::MaxRowBytes) begin
      len = LW'(bsd_pkg::MaxRowBytes);
    end else begin
      len = LW'(rb);
    end
    return len;
  endfunction

  function automatic bsd_pkg::row_step_t advance_f(input logic [AW-1:0] pos,
                                                    input logic [bsd_pkg::FlagPosW-1:0] fp,
                                                    input logic [LW-1:0] len);
    bsd_pkg::row_step_t s;
    logic [LW-1:0] nxt;
    nxt    = LW'(pos) + LW'(1);
    s.fpos = (fp < bsd_pkg::FlagDone) ? fp + 4'd1 : fp;
    if (nxt >= len) begin
      s.pos  = '0;
      s.fpos = bsd_pkg::FlagDone;
    end else begin
      s.pos = nxt[AW-1:0];
    end
    return s;
  endfunction

  // True when the flag walk would emit a copy at this flag position.
  function automatic logic copy_next_f(input logic [bsd_pkg::FlagPosW-1:0] fp,
                                       input logic [bsd_pkg::ByteW-1:0] flags);
    logic [2:0] idx;
    idx = ~fp[2:0];
    return (fp < bsd_pkg::FlagDone) && !flags[idx];
  endfunction

  // Configuration
  logic [bsd_pkg::ModeW-1:0]    mode_r, mode_nxt;
  logic [bsd_pkg::CfgDataW-1:0] row_bytes_r, row_bytes_nxt;

  // Control and decoder state
  bsd_pkg::ctl_t                ctl_r, ctl_nxt;
  bsd_pkg::phase_t              phase_r, phase_nxt;
  logic [bsd_pkg::LenW-1:0]     bytes_rem_r, bytes_rem_nxt;
  logic [AW-1:0]                row_pos_r, row_pos_nxt;
  logic [bsd_pkg::FlagPosW-1:0] fpos_r, fpos_nxt;
  logic [bsd_pkg::ByteW-1:0]    flag_bits_r, flag_bits_nxt;
  logic [bsd_pkg::ByteW-1:0]    pend_r, pend_nxt;
  logic [LW-1:0]                fill_r, fill_nxt;

  // Held item
  logic [bsd_pkg::ByteW-1:0]    item_byte_r, item_byte_nxt;
  logic                         item_first_r, item_first_nxt;

  // Result register
  logic                         out_valid_r, out_valid_nxt;
  logic [bsd_pkg::ByteW-1:0]    out_byte_r, out_byte_nxt;
  logic [bsd_pkg::ByteW-1:0]    out_cnt_r, out_cnt_nxt;
  logic                         out_last_r, out_last_nxt;

  // Row store
  logic [bsd_pkg::ByteW-1:0]    row_mem [bsd_pkg::MaxRowBytes];
  logic [bsd_pkg::ByteW-1:0]    rd_data_r;
  logic                         mem_we, mem_re;
  logic [bsd_pkg::ByteW-1:0]    mem_wdata;

  logic [LW-1:0]                row_len;
  bsd_pkg::row_step_t           adv;
  logic                         out_free;
  logic                         needs_emit;
  logic                         go;
  logic [bsd_pkg::LenW-1:0]     rem_dec;
  logic [bsd_pkg::ByteW-1:0]    pend_dec;
  logic [bsd_pkg::ByteW-1:0]    copy_val;
  logic                         pos_is_fill;

  assign row_len     = row_len_f(row_bytes_r);
  assign adv         = advance_f(row_pos_r, fpos_r, row_len);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign rem_dec     = bytes_rem_r - 16'd1;
  assign pend_dec    = (pend_r != '0) ? pend_r - 8'd1 : pend_r;
  assign pos_is_fill = (LW'(row_pos_r) == fill_r);
  // entries at or past the fill count were not written since the bitmap began
  assign copy_val    = (LW'(row_pos_r) < fill_r) ? rd_data_r : '0;

  assign needs_emit = (phase_r == bsd_pkg::PH_LITERAL) ||
                      ((phase_r == bsd_pkg::PH_BODY) &&
                       ((mode_r == bsd_pkg::MODE_SCAN) ||
                        (((mode_r == bsd_pkg::MODE_RLE) || (mode_r == bsd_pkg::MODE_PACKBITS)) &&
                         (pend_r != '0))));
  assign go = !needs_emit || out_free;

  assign in_ch.ready         = (ctl_r == bsd_pkg::CTL_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.repeat_count = out_cnt_r;
  assign out_ch.last_of_item = out_last_r;

  always_comb begin
    mode_nxt      = mode_r;
    row_bytes_nxt = row_bytes_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bsd_pkg::CFG_MODE:      mode_nxt      = cfg_wdata[bsd_pkg::ModeW-1:0];
        bsd_pkg::CFG_ROW_BYTES: row_bytes_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl_nxt        = ctl_r;
    phase_nxt      = phase_r;
    bytes_rem_nxt  = bytes_rem_r;
    row_pos_nxt    = row_pos_r;
    fpos_nxt       = fpos_r;
    flag_bits_nxt  = flag_bits_r;
    pend_nxt       = pend_r;
    fill_nxt       = fill_r;
    item_byte_nxt  = item_byte_r;
    item_first_nxt = item_first_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wdata      = item_byte_r;

    unique case (ctl_r)
      bsd_pkg::CTL_IDLE: begin
        if (in_ch.valid) begin
          item_byte_nxt  = in_ch.data_byte;
          item_first_nxt = in_ch.first_byte;
          ctl_nxt        = bsd_pkg::CTL_EXEC;
        end
      end

      bsd_pkg::CTL_EXEC: begin
        if (item_first_r) begin
          // new bitmap: drop everything, row store empties via the fill count
          fill_nxt      = '0;
          row_pos_nxt   = '0;
          fpos_nxt      = '0;
          flag_bits_nxt = '0;
          pend_nxt      = '0;
          bytes_rem_nxt = {8'h00, item_byte_r};
          phase_nxt     = bsd_pkg::PH_WAIT_LO;
          ctl_nxt       = bsd_pkg::CTL_IDLE;
        end else if (phase_r == bsd_pkg::PH_WAIT_HI) begin
          ctl_nxt = bsd_pkg::CTL_IDLE;
        end else if (phase_r == bsd_pkg::PH_WAIT_LO) begin
          if ({bytes_rem_r[7:0], item_byte_r} >= 16'd2) begin
            bytes_rem_nxt = {bytes_rem_r[7:0], item_byte_r} - 16'd2;
          end else begin
            bytes_rem_nxt = '0;
          end
          phase_nxt = (bytes_rem_nxt != '0) ? bsd_pkg::PH_HEAD : bsd_pkg::PH_WAIT_HI;
          ctl_nxt   = bsd_pkg::CTL_IDLE;
        end else if (go) begin
          bytes_rem_nxt = rem_dec;
          ctl_nxt       = bsd_pkg::CTL_IDLE;
          unique case (phase_r)
            bsd_pkg::PH_LITERAL: begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = item_byte_r;
              out_cnt_nxt   = 8'd1;
              out_last_nxt  = 1'b1;
              pend_nxt      = pend_dec;
              if (pend_dec == '0) begin
                phase_nxt = bsd_pkg::PH_HEAD;
              end
            end
            bsd_pkg::PH_HEAD: begin
              unique case (mode_r)
                bsd_pkg::MODE_SCAN: begin
                  flag_bits_nxt = item_byte_r;
                  fpos_nxt      = '0;
                  ctl_nxt       = bsd_pkg::CTL_DRAIN;
                end
                bsd_pkg::MODE_RLE: begin
                  pend_nxt  = item_byte_r;
                  phase_nxt = bsd_pkg::PH_BODY;
                end
                bsd_pkg::MODE_PACKBITS: begin
                  if (!item_byte_r[7]) begin
                    pend_nxt  = item_byte_r + 8'd1;
                    phase_nxt = bsd_pkg::PH_LITERAL;
                  end else if (item_byte_r != bsd_pkg::PbNop) begin
                    pend_nxt  = 8'(9'd257 - {1'b0, item_byte_r});
                    phase_nxt = bsd_pkg::PH_BODY;
                  end
                end
                default: ;
              endcase
            end
            bsd_pkg::PH_BODY: begin
              if (mode_r == bsd_pkg::MODE_SCAN) begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = item_byte_r;
                out_cnt_nxt   = 8'd1;
                out_last_nxt  = !copy_next_f(adv.fpos, flag_bits_r);
                mem_we        = 1'b1;
                mem_wdata     = item_byte_r;
                if (pos_is_fill) begin
                  fill_nxt = fill_r + LW'(1);
                end
                row_pos_nxt = adv.pos;
                fpos_nxt    = adv.fpos;
                ctl_nxt     = bsd_pkg::CTL_DRAIN;
              end else begin
                if (needs_emit) begin
                  out_valid_nxt = 1'b1;
                  out_byte_nxt  = item_byte_r;
                  out_cnt_nxt   = pend_r;
                  out_last_nxt  = 1'b1;
                end
                phase_nxt = bsd_pkg::PH_HEAD;
              end
            end
            default: ;
          endcase
          // the flag walk settles the phase itself when it ends
          if (rem_dec == '0 && ctl_nxt == bsd_pkg::CTL_IDLE) begin
            phase_nxt = bsd_pkg::PH_WAIT_HI;
          end
        end
      end

      bsd_pkg::CTL_DRAIN: begin
        if (copy_next_f(fpos_r, flag_bits_r)) begin
          mem_re  = 1'b1;
          ctl_nxt = bsd_pkg::CTL_COPY;
        end else begin
          ctl_nxt = bsd_pkg::CTL_IDLE;
          if (bytes_rem_r == '0) begin
            phase_nxt = bsd_pkg::PH_WAIT_HI;
          end else if (fpos_r < bsd_pkg::FlagDone) begin
            phase_nxt = bsd_pkg::PH_BODY;
          end else begin
            phase_nxt = bsd_pkg::PH_HEAD;
          end
        end
      end

      bsd_pkg::CTL_COPY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = copy_val;
          out_cnt_nxt   = 8'd1;
          out_last_nxt  = !copy_next_f(adv.fpos, flag_bits_r);
          // write the copy back so the entry counts as filled
          mem_we        = 1'b1;
          mem_wdata     = copy_val;
          if (pos_is_fill) begin
            fill_nxt = fill_r + LW'(1);
          end
          row_pos_nxt = adv.pos;
          fpos_nxt    = adv.fpos;
          ctl_nxt     = bsd_pkg::CTL_DRAIN;
        end
      end

      default: ctl_nxt = bsd_pkg::CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= bsd_pkg::MODE_SCAN;
      row_bytes_r <= bsd_pkg::CfgDataW'(1);
      ctl_r       <= bsd_pkg::CTL_IDLE;
      phase_r     <= bsd_pkg::PH_WAIT_HI;
      bytes_rem_r <= '0;
      row_pos_r   <= '0;
      fpos_r      <= '0;
      flag_bits_r <= '0;
      pend_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      row_bytes_r <= row_bytes_nxt;
      ctl_r       <= ctl_nxt;
      phase_r     <= phase_nxt;
      bytes_rem_r <= bytes_rem_nxt;
      row_pos_r   <= row_pos_nxt;
      fpos_r      <= fpos_nxt;
      flag_bits_r <= flag_bits_nxt;
      pend_r      <= pend_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_byte_r  <= item_byte_nxt;
    item_first_r <= item_first_nxt;
    out_byte_r   <= out_byte_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Previous-row store: one write or one read per cycle, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[row_pos_r] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= row_mem[row_pos_r];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bsd_checker.sv @@
// Port-level checks of the bitmap stream decompressor and their bind.
`default_nettype none
`include "assert_macros.svh"

module bsd_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [bsd_pkg::ByteW-1:0]   out_repeat_count
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `BSD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped before taken")
  `BSD_ASSERT(a_count_nonzero, clk, rst_n, out_valid |-> out_repeat_count != 8'd0, "zero repeat count")
  `BSD_ASSERT(a_one_item_at_a_time, clk, rst_n, in_acc |=> !in_ready, "item taken while busy")
  `BSD_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_valid, "result present after reset")

endmodule

bind bitmap_stream_decompressor bsd_checker u_bsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_repeat_count (out_ch.repeat_count)
);

`default_nettype wire
